// ===== sv/leq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leq_pkg: shared types and constants
// Widths, register codes and reset values for the linear extrapolation
// quantizer, plus the result type of the shared compare/subtract unit.
// ----------------------------------------------------------------------------
package leq_pkg;

  // coordinate width of the stored reconstructions (default)
  localparam int COORD_BITS_DEF = 32;

  // fixed field widths
  localparam int IO_W        = 32;
  localparam int HALF_STEP_W = 30;
  localparam int BOUND_W     = 32;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_BOUND = 1'b1;
  localparam logic [HALF_STEP_W-1:0] HALF_STEP_RST = 30'd71;
  localparam logic [BOUND_W-1:0]     BOUND_RST     = 32'd100;

  // prediction used for the very first point: 2.0 degrees
  localparam logic signed [IO_W-1:0] FIRST_PRED = 32'sd20000000;

  // shared compare/subtract unit width (covers divide and square root)
  localparam int UW = 35;

  // multiplier and square root sizes
  localparam int MUL_W      = 32;
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic          ge;   // minuend was >= subtrahend
    logic [UW-1:0] res;  // conditionally reduced value
  } csub_res_t;

endpackage
`default_nettype wire

// ===== sv/leq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leq_if: point and result channels
// Valid/ready channels carrying one input point word and one result word.
// ----------------------------------------------------------------------------
interface leq_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [leq_pkg::IO_W-1:0]    longitude;
  logic signed [leq_pkg::IO_W-1:0]    latitude;

  modport source (output valid, output longitude, output latitude, input ready);
  modport sink   (input valid, input longitude, input latitude, output ready);
endinterface

interface leq_out_if;
  logic                               valid;
  logic                               ready;
  logic                               prediction_valid;
  logic                               accurate;
  logic [leq_pkg::IO_W-1:0]           error_distance;
  logic signed [leq_pkg::IO_W-1:0]    recon_longitude;
  logic signed [leq_pkg::IO_W-1:0]    recon_latitude;

  modport source (output valid, output prediction_valid, output accurate,
                  output error_distance, output recon_longitude,
                  output recon_latitude, input ready);
  modport sink   (input valid, input prediction_valid, input accurate,
                  input error_distance, input recon_longitude,
                  input recon_latitude, output ready);
endinterface
`default_nettype wire

// ===== sv/linear_extrapolation_quantizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_extrapolation_quantizer: error-bounded linear prediction quantizer
// Per point: residual, magnitude, per-axis divide and reconstruction, then the
// error path (squares, bound compare, root), which the first two points skip.
// A new point is taken only once the result word is handed over. On the shared
// unit, NW = max(COORD_BITS,32)+4 divide steps per axis and 32 root steps run.
// Sync reset: half step 71, error bound 100, history and count cleared.
// ----------------------------------------------------------------------------
module linear_extrapolation_quantizer #(
  parameter int COORD_BITS = leq_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [leq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [leq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  leq_in_if.sink                             in_ch,
  leq_out_if.source                          out_ch
);

  localparam int EW = (COORD_BITS > leq_pkg::IO_W) ? COORD_BITS : leq_pkg::IO_W;
  localparam int PW = EW + 2;       // prediction
  localparam int AW = PW + 1;       // residual and its magnitude
  localparam int NW = AW + 1;       // dividend: magnitude plus half step
  localparam int RW = NW + 2;       // unsaturated reconstruction
  localparam int CW = $clog2(NW);   // step counter

  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_ONE  = 2'd1;
  localparam logic [1:0] PS_TWO  = 2'd2;

  localparam logic signed [RW-1:0] SAT_HI = {{(RW-COORD_BITS+1){1'b0}},
                                             {(COORD_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-COORD_BITS+1){1'b1}},
                                             {(COORD_BITS-1){1'b0}}};

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_RES   = 12'b0000_0000_0010,
    S_ABS   = 12'b0000_0000_0100,
    S_DINIT = 12'b0000_0000_1000,
    S_DIV   = 12'b0000_0001_0000,
    S_DFIN  = 12'b0000_0010_0000,
    S_REC   = 12'b0000_0100_0000,
    S_SQX   = 12'b0000_1000_0000,
    S_SQY   = 12'b0001_0000_0000,
    S_SQE   = 12'b0010_0000_0000,
    S_SCMP  = 12'b0100_0000_0000,
    S_SQRT  = 12'b1000_0000_0000
  } state_t;

  // the done flag has no state_t code: it is kept in its own done_t register below
  typedef enum logic [12:0] {
    D_OFF = 13'b0_0000_0000_0001,
    D_ON  = 13'b1_0000_0000_0000
  } done_t;

  state_t state_r, state_nxt;
  done_t  done_r,  done_nxt;

  // configuration
  logic [leq_pkg::HALF_STEP_W-1:0] half_step_r;
  logic [leq_pkg::BOUND_W-1:0]     bound_r;

  // history
  logic signed [COORD_BITS-1:0] last_r [2];
  logic signed [COORD_BITS-1:0] prior_r [2];
  logic [1:0]                   points_seen_r;

  // working registers
  logic signed [leq_pkg::IO_W-1:0] act_r  [2];
  logic signed [PW-1:0]            pred_r [2];
  logic signed [AW-1:0]            res_r  [2];
  logic [AW-1:0]                   mag_r  [2];
  logic signed [COORD_BITS-1:0]    rec_r  [2];
  logic                            ax_r;
  logic [NW-1:0]                   n_r;
  logic [NW-1:0]                   off_r;
  logic [leq_pkg::UW-1:0]          rem_r;
  logic [CW-1:0]                   cnt_r;
  logic [leq_pkg::SQ_W:0]          sum_r;
  logic [leq_pkg::ROOT_W-1:0]      root_r;
  logic                            acc_r;
  logic                            sat_r;

  // result word
  logic                            out_valid_r;
  logic                            out_pv_r;
  logic                            out_acc_r;
  logic [leq_pkg::IO_W-1:0]        out_dist_r;
  logic [leq_pkg::IO_W-1:0]        out_rlon_r;
  logic [leq_pkg::IO_W-1:0]        out_rlat_r;

  logic                            in_fire;
  logic                            out_load;
  logic                            pred_ok;
  logic signed [PW-1:0]            pred_in [2];
  logic signed [AW-1:0]            res_in  [2];
  logic [AW-1:0]                   mag_in  [2];
  logic signed [RW-1:0]            pred_x;
  logic signed [RW-1:0]            off_x;
  logic signed [RW-1:0]            rsum;
  logic signed [COORD_BITS-1:0]    rec_val;
  logic signed [EW-1:0]            rec_ext [2];
  logic                            big_err;
  logic [leq_pkg::UW-1:0]          cs_min;
  logic [leq_pkg::UW-1:0]          cs_sub;
  leq_pkg::csub_res_t              cs_res;
  logic                            mul_en;
  logic [leq_pkg::MUL_W-1:0]       mul_op;
  logic [leq_pkg::SQ_W-1:0]        mul_prod;

  assign in_ch.ready = (state_r == S_IDLE) && (done_r == D_OFF);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (done_r == D_ON) && (!out_valid_r || out_ch.ready);
  assign pred_ok     = (points_seen_r == PS_TWO);

  // per-axis prediction, residual and magnitude lanes
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      unique case (points_seen_r)
        PS_NONE: pred_in[i] = PW'(leq_pkg::FIRST_PRED);
        PS_ONE:  pred_in[i] = PW'(last_r[i]);
        default: pred_in[i] = (PW'(last_r[i]) <<< 1) - PW'(prior_r[i]);
      endcase
      res_in[i] = AW'(act_r[i]) - AW'(pred_r[i]);
      mag_in[i] = res_r[i][AW-1] ? AW'(-res_r[i]) : AW'(res_r[i]);
    end
  end

  // reconstruction of the current axis, saturated to the coordinate range
  always_comb begin
    pred_x = RW'(pred_r[ax_r]);
    off_x  = $signed(RW'(off_r));
    rsum   = res_r[ax_r][AW-1] ? (pred_x - off_x) : (pred_x + off_x);
    priority if (rsum > SAT_HI) begin
      rec_val = SAT_HI[COORD_BITS-1:0];
    end else if (rsum < SAT_LO) begin
      rec_val = SAT_LO[COORD_BITS-1:0];
    end else begin
      rec_val = rsum[COORD_BITS-1:0];
    end
  end

  assign big_err = (|mag_r[0][AW-1:leq_pkg::ROOT_W]) | (|mag_r[1][AW-1:leq_pkg::ROOT_W]);

  // shared unit operands: root step or remainder step
  always_comb begin
    if (state_r == S_SQRT) begin
      cs_min = {rem_r[leq_pkg::UW-3:0], sum_r[leq_pkg::SQ_W-1 -: 2]};
      cs_sub = leq_pkg::UW'({root_r, 2'b01});
    end else begin
      cs_min = {rem_r[leq_pkg::UW-2:0], n_r[cnt_r]};
      cs_sub = leq_pkg::UW'({half_step_r, 1'b0});
    end
  end

  leq_csub u_csub (
    .min_i (cs_min),
    .sub_i (cs_sub),
    .res_o (cs_res)
  );

  // multiplier operand: x error, y error, then the bound
  always_comb begin
    mul_en = (state_r == S_SQX) || (state_r == S_SQY) || (state_r == S_SQE);
    unique case (state_r)
      S_SQX:   mul_op = mag_r[0][leq_pkg::MUL_W-1:0];
      S_SQY:   mul_op = mag_r[1][leq_pkg::MUL_W-1:0];
      default: mul_op = bound_r;
    endcase
  end

  leq_mul u_mul (
    .clk    (clk),
    .en_i   (mul_en),
    .a_i    (mul_op),
    .b_i    (mul_op),
    .prod_o (mul_prod)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    unique case (state_r)
      S_IDLE: begin
        if (done_r == D_ON) begin
          if (out_load) begin
            done_nxt = D_OFF;
          end
        end else if (in_fire) begin
          state_nxt = S_RES;
        end
      end
      S_RES:   state_nxt = S_ABS;
      S_ABS:   state_nxt = S_DINIT;
      S_DINIT: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN:  state_nxt = S_REC;
      S_REC: begin
        priority if (!ax_r) begin
          state_nxt = S_DINIT;
        end else if (pred_ok) begin
          state_nxt = S_SQX;
        end else begin
          state_nxt = S_IDLE;
          done_nxt  = D_ON;
        end
      end
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_SQE;
      S_SQE:   state_nxt = S_SCMP;
      S_SCMP:  state_nxt = S_SQRT;
      S_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = S_IDLE;
          done_nxt  = D_ON;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, configuration and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      done_r        <= D_OFF;
      half_step_r   <= leq_pkg::HALF_STEP_RST;
      bound_r       <= leq_pkg::BOUND_RST;
      points_seen_r <= PS_NONE;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        last_r[i]  <= '0;
        prior_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          leq_pkg::REG_HALF_STEP:   half_step_r   <= cfg_wdata[leq_pkg::HALF_STEP_W-1:0];
          leq_pkg::REG_ERROR_BOUND: bound_r       <= cfg_wdata[leq_pkg::BOUND_W-1:0];
        endcase
      end
      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // history moves on when the result word is handed over
      if (out_load) begin
        for (int i = 0; i < 2; i++) begin
          prior_r[i] <= last_r[i];
          last_r[i]  <= rec_r[i];
        end
        if (points_seen_r != PS_TWO) begin
          points_seen_r <= points_seen_r + 2'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_r[0]  <= in_ch.longitude;
          act_r[1]  <= in_ch.latitude;
          pred_r[0] <= pred_in[0];
          pred_r[1] <= pred_in[1];
        end
      end
      S_RES: begin
        res_r[0] <= res_in[0];
        res_r[1] <= res_in[1];
      end
      S_ABS: begin
        mag_r[0] <= mag_in[0];
        mag_r[1] <= mag_in[1];
        ax_r     <= 1'b0;
      end
      S_DINIT: begin
        n_r   <= NW'(mag_r[ax_r]) + NW'(half_step_r);
        rem_r <= '0;
        cnt_r <= CW'(NW - 1);
      end
      S_DIV: begin
        rem_r <= cs_res.res;
        cnt_r <= cnt_r - CW'(1);
      end
      S_DFIN: begin
        // step times quotient is the dividend less the remainder
        off_r <= (half_step_r == '0) ? n_r : (n_r - NW'(rem_r));
      end
      S_REC: begin
        rec_r[ax_r] <= rec_val;
        ax_r        <= 1'b1;
      end
      S_SQX: begin
      end
      S_SQY: begin
        sum_r <= (leq_pkg::SQ_W + 1)'(mul_prod);
      end
      S_SQE: begin
        sum_r <= sum_r + (leq_pkg::SQ_W + 1)'(mul_prod);
      end
      S_SCMP: begin
        acc_r  <= !big_err && !sum_r[leq_pkg::SQ_W] &&
                  (sum_r[leq_pkg::SQ_W-1:0] <= mul_prod);
        sat_r  <= big_err | sum_r[leq_pkg::SQ_W];
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CW'(leq_pkg::SQRT_STEPS - 1);
      end
      S_SQRT: begin
        rem_r  <= cs_res.res;
        root_r <= {root_r[leq_pkg::ROOT_W-2:0], cs_res.ge};
        sum_r  <= {sum_r[leq_pkg::SQ_W], sum_r[leq_pkg::SQ_W-3:0], 2'b00};
        cnt_r  <= cnt_r - CW'(1);
      end
      default: begin
      end
    endcase
  end

  // result word fields
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rec_ext[i] = EW'(rec_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pv_r   <= pred_ok;
      out_acc_r  <= pred_ok && acc_r;
      out_dist_r <= !pred_ok ? '0 : (sat_r ? '1 : root_r);
      out_rlon_r <= rec_ext[0][leq_pkg::IO_W-1:0];
      out_rlat_r <= rec_ext[1][leq_pkg::IO_W-1:0];
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.prediction_valid = out_pv_r;
  assign out_ch.accurate         = out_acc_r;
  assign out_ch.error_distance   = out_dist_r;
  assign out_ch.recon_longitude  = out_rlon_r;
  assign out_ch.recon_latitude   = out_rlat_r;

endmodule
`default_nettype wire

// ===== sv/leq_csub.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leq_csub: shared compare and conditional subtract
// One restoring step: if the minuend reaches the subtrahend, subtract it.
// Serves both the remainder division and the integer square root.
// ----------------------------------------------------------------------------
module leq_csub (
  input  logic [leq_pkg::UW-1:0] min_i,
  input  logic [leq_pkg::UW-1:0] sub_i,
  output leq_pkg::csub_res_t     res_o
);

  logic [leq_pkg::UW:0] diff;

  // borrow out of the wide subtract decides the step
  assign diff      = {1'b0, min_i} - {1'b0, sub_i};
  assign res_o.ge  = ~diff[leq_pkg::UW];
  assign res_o.res = diff[leq_pkg::UW] ? min_i : diff[leq_pkg::UW-1:0];

endmodule
`default_nettype wire

// ===== sv/leq_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leq_mul: registered 32x32 multiplier
// Squares the axis errors and the error bound, one product per cycle while enabled.
// ----------------------------------------------------------------------------
module leq_mul (
  input  logic                          clk,
  input  logic                          en_i,
  input  logic [leq_pkg::MUL_W-1:0]     a_i,
  input  logic [leq_pkg::MUL_W-1:0]     b_i,
  output logic [leq_pkg::SQ_W-1:0]      prod_o
);

  logic [leq_pkg::SQ_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en_i) begin
      prod_r <= leq_pkg::SQ_W'(a_i) * leq_pkg::SQ_W'(b_i);
    end
  end

  assign prod_o = prod_r;

endmodule
`default_nettype wire
